// ----- hdl/bsad_pkg.sv -----
package bsad_pkg;

  // Capacity of the element store
  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  // Request from the sequencer to the element store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- hdl/bsad_store.sv -----
module bsad_store (
  input  logic                     clk,
  input  bsad_pkg::mem_req_t       req,
  output logic [bsad_pkg::DATA_W-1:0] rdata
);
  import bsad_pkg::*;

  logic [DATA_W-1:0] mem [MAX_ITEMS];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- hdl/bounded_sort_asc_desc_core.sv -----
// Loads one request per cycle while loading; the request with last_in starts the sort.
// The sort makes one compare per cycle, through the single read port of the element
// store. Results then follow one at a time (store read, then output register).
// No request is taken from the last_in request until the last result is registered.
// rst (synchronous) clears the count, the sequencer, the output valid and the order bit.
module bounded_sort_asc_desc_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bsad_pkg::DATA_W-1:0]  value,
  input  logic                                last_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bsad_pkg::DATA_W-1:0]  sorted_value,
  output logic                                last_out,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata
);
  import bsad_pkg::*;

  typedef enum logic [6:0] {
    ST_LOAD    = 7'b0000001,
    ST_RD_I    = 7'b0000010,
    ST_LD_X    = 7'b0000100,
    ST_CMP     = 7'b0001000,
    ST_WB_I    = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WT = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx_i;
  logic [IDX_W-1:0]  idx_j;
  logic [IDX_W-1:0]  idx_k;
  logic [DATA_W-1:0] x;
  logic              sort_descending;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  logic              in_acc;
  logic              room;
  logic [CNT_W-1:0]  count_after;
  logic              swap;
  logic              j_end;
  logic              i_end;
  logic              k_end;
  logic              out_load;

  bsad_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign in_ready    = (state == ST_LOAD);
  assign in_acc      = in_valid && in_ready;
  assign room        = (count < CNT_W'(MAX_ITEMS));
  assign count_after = room ? count + CNT_W'(1) : count;

  // Compare held element x (position i) with store[j]
  assign swap  = sort_descending ? ($signed(mem_rdata) > $signed(x))
                                 : ($signed(x) > $signed(mem_rdata));
  assign j_end = (CNT_W'(idx_j) + CNT_W'(1) == count);
  assign i_end = (CNT_W'(idx_i) + CNT_W'(2) == count);
  assign k_end = (CNT_W'(idx_k) + CNT_W'(1) == count);

  assign out_load = (state == ST_EMIT_WT) && (!out_valid || out_ready);

  // Store requests per state
  always_comb begin
    mem_req = '0;
    unique case (state)
      ST_LOAD: begin
        mem_req.we    = in_acc && room;
        mem_req.waddr = count[IDX_W-1:0];
        mem_req.wdata = value;
      end
      ST_RD_I: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_i;
      end
      ST_LD_X: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_j;
      end
      ST_CMP: begin
        mem_req.we    = swap;
        mem_req.waddr = idx_j;
        mem_req.wdata = x;
        mem_req.re    = !j_end;
        mem_req.raddr = idx_j + IDX_W'(1);
      end
      ST_WB_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_i;
        mem_req.wdata = x;
        mem_req.re    = !i_end;
        mem_req.raddr = idx_i + IDX_W'(1);
      end
      ST_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_k;
      end
      ST_EMIT_WT: begin
        mem_req = '0;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && last_in) begin
          state_next = (count_after > CNT_W'(1)) ? ST_RD_I : ST_EMIT_RD;
        end
      end
      ST_RD_I:    state_next = ST_LD_X;
      ST_LD_X:    state_next = ST_CMP;
      ST_CMP: begin
        if (j_end) begin
          state_next = ST_WB_I;
        end
      end
      ST_WB_I:    state_next = i_end ? ST_EMIT_RD : ST_LD_X;
      ST_EMIT_RD: state_next = ST_EMIT_WT;
      ST_EMIT_WT: begin
        if (out_load) begin
          state_next = k_end ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      count           <= '0;
      out_valid       <= 1'b0;
      sort_descending <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        sort_descending <= cfg_wdata;
      end
      if (in_acc) begin
        count <= count_after;
      end else if (out_load && k_end) begin
        count <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Indices, held element and output payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        idx_i <= '0;
        idx_j <= IDX_W'(1);
        idx_k <= '0;
      end
      ST_LD_X: begin
        x <= mem_rdata;
      end
      ST_CMP: begin
        if (swap) begin
          x <= mem_rdata;
        end
        if (!j_end) begin
          idx_j <= idx_j + IDX_W'(1);
        end
      end
      ST_WB_I: begin
        if (!i_end) begin
          idx_i <= idx_i + IDX_W'(1);
          idx_j <= idx_i + IDX_W'(2);
        end
      end
      ST_EMIT_WT: begin
        if (out_load) begin
          sorted_value <= mem_rdata;
          last_out     <= k_end;
          idx_k        <= idx_k + IDX_W'(1);
        end
      end
      ST_RD_I, ST_EMIT_RD: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_in |=> !in_ready)
    else $error("request taken while a set is being sorted");

  a_j_after_i: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> idx_j > idx_i)
    else $error("compare position not after held position");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    out_load && k_end |=> count == '0 && state == ST_LOAD)
    else $error("count not cleared after final result");
`endif

endmodule
